/* hw/rtl/evhp_pkg.sv */
`default_nettype none

package evhp_pkg;

  // Longest frame that the byte counter tracks; longer frames count as this long.
  localparam int unsigned MaxFrameBytes = 16383;
  localparam int unsigned PosW          = $clog2(MaxFrameBytes + 1);

  // Result payload length saturates at this value.
  localparam int unsigned PayW          = 14;
  localparam int unsigned PayloadMax    = (1 << PayW) - 1;
  localparam int unsigned CmpW          = (PosW > PayW) ? PosW : PayW;

  // Frame layout, in byte offsets.
  localparam int unsigned DestEnd       = 6;
  localparam int unsigned SrcEnd        = 12;
  localparam int unsigned TypeEnd       = 14;
  localparam int unsigned TagEnd        = 16;
  localparam int unsigned InnerEnd      = 18;

  localparam logic [4:0]  HdrUntagged   = 5'd14;
  localparam logic [4:0]  HdrTagged     = 5'd18;
  localparam logic [4:0]  HdrNone       = 5'd0;

  localparam logic [15:0] LengthLimit   = 16'd1500;
  localparam logic [15:0] VlanTpid      = 16'h8100;

  localparam logic        StatusOk      = 1'b0;
  localparam logic        StatusShort   = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic            status;
    logic [47:0]     dest_addr;
    logic [47:0]     src_addr;
    logic [15:0]     ether_type;
    logic            vlan_present;
    logic [11:0]     vlan_id;
    logic [2:0]      priority_res;
    logic            drop_eligible;
    logic [4:0]      header_size;
    logic [PayW-1:0] payload_length;
  } hdr_result_t;

endpackage

`default_nettype wire

/* hw/rtl/evhp_if.sv */
`default_nettype none

// Byte stream channel: one frame byte per transfer.
interface evhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Header result channel: one result per frame.
interface evhp_hdr_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [47:0]               dest_addr;
  logic [47:0]               src_addr;
  logic [15:0]               ether_type;
  logic                      vlan_present;
  logic [11:0]               vlan_id;
  logic [2:0]                priority_res;
  logic                      drop_eligible;
  logic [4:0]                header_size;
  logic [evhp_pkg::PayW-1:0] payload_length;

  modport source (output valid, output status, output dest_addr, output src_addr,
                  output ether_type, output vlan_present, output vlan_id,
                  output priority_res, output drop_eligible, output header_size,
                  output payload_length, input ready);
  modport sink   (input valid, input status, input dest_addr, input src_addr,
                  input ether_type, input vlan_present, input vlan_id,
                  input priority_res, input drop_eligible, input header_size,
                  input payload_length, output ready);
endinterface

`default_nettype wire

/* hw/rtl/evhp_in_stage.sv */
`default_nettype none

module evhp_in_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  evhp_byte_if.sink            rx_i,
  input  wire                  advance_i,
  output logic                 item_valid_o,
  output evhp_pkg::byte_item_t item_o
);

  logic                 valid_q;
  evhp_pkg::byte_item_t item_q;
  logic                 take;

  // The register can take a new byte when empty or when its byte moves on.
  assign rx_i.ready = !valid_q || advance_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      valid_q <= rx_i.valid;
    end
  end

  // Payload holds no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.data_byte <= rx_i.data_byte;
      item_q.last_byte <= rx_i.last_byte;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

/* hw/rtl/evhp_parse.sv */
`default_nettype none

module evhp_parse (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        item_valid_i,
  input  wire evhp_pkg::byte_item_t  item_i,
  input  wire                        slot_free_i,
  output logic                       advance_o,
  output logic                       res_valid_o,
  output evhp_pkg::hdr_result_t      res_o
);

  localparam int unsigned PosW = evhp_pkg::PosW;
  localparam int unsigned CmpW = evhp_pkg::CmpW;

  logic [PosW-1:0] pos_q, pos_d;
  logic [47:0]     dest_q, dest_d;
  logic [47:0]     src_q, src_d;
  logic [15:0]     outer_q, outer_d;
  logic [15:0]     tag_q, tag_d;
  logic [15:0]     inner_q, inner_d;

  logic [7:0]      b;
  logic            is_tagged;
  logic [4:0]      hdr;
  logic [PosW-1:0] pay;
  logic [CmpW-1:0] pay_ext;

  assign b = item_i.data_byte;

  // A non-final byte always moves on; the final one needs room for its result.
  assign advance_o   = item_valid_i && (!item_i.last_byte || slot_free_i);
  assign res_valid_o = advance_o && item_i.last_byte;

  // Shift the byte into the field that owns its offset, and step the counter.
  always_comb begin
    dest_d  = dest_q;
    src_d   = src_q;
    outer_d = outer_q;
    tag_d   = tag_q;
    inner_d = inner_q;
    if (pos_q < PosW'(evhp_pkg::DestEnd)) begin
      dest_d = {dest_q[39:0], b};
    end else if (pos_q < PosW'(evhp_pkg::SrcEnd)) begin
      src_d = {src_q[39:0], b};
    end else if (pos_q < PosW'(evhp_pkg::TypeEnd)) begin
      outer_d = {outer_q[7:0], b};
    end else if (pos_q < PosW'(evhp_pkg::TagEnd)) begin
      tag_d = {tag_q[7:0], b};
    end else if (pos_q < PosW'(evhp_pkg::InnerEnd)) begin
      inner_d = {inner_q[7:0], b};
    end
    if (pos_q < PosW'(evhp_pkg::MaxFrameBytes)) begin
      pos_d = pos_q + PosW'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  // Build the result from the fields including the final byte.
  always_comb begin
    is_tagged = (outer_d == evhp_pkg::VlanTpid);
    res_o     = '0;
    hdr       = evhp_pkg::HdrNone;
    if (pos_d < PosW'(evhp_pkg::TypeEnd)) begin
      res_o.status = evhp_pkg::StatusShort;
    end else if (is_tagged) begin
      if (pos_d < PosW'(evhp_pkg::InnerEnd)) begin
        res_o.status = evhp_pkg::StatusShort;
      end else begin
        hdr                 = evhp_pkg::HdrTagged;
        res_o.vlan_present  = 1'b1;
        res_o.vlan_id       = tag_d[11:0];
        res_o.priority_res  = tag_d[15:13];
        res_o.drop_eligible = tag_d[12];
        res_o.ether_type    = (inner_d > evhp_pkg::LengthLimit) ? inner_d : 16'd0;
      end
    end else begin
      hdr              = evhp_pkg::HdrUntagged;
      res_o.ether_type = (outer_d > evhp_pkg::LengthLimit) ? outer_d : 16'd0;
    end

    pay     = pos_d - PosW'(hdr);
    pay_ext = CmpW'(pay);
    if (res_o.status == evhp_pkg::StatusOk) begin
      res_o.dest_addr   = dest_d;
      res_o.src_addr    = src_d;
      res_o.header_size = hdr;
      if (pay_ext > CmpW'(evhp_pkg::PayloadMax)) begin
        res_o.payload_length = evhp_pkg::PayW'(evhp_pkg::PayloadMax);
      end else begin
        res_o.payload_length = evhp_pkg::PayW'(pay_ext);
      end
    end
  end

  // Byte counter: restarts after the final byte of a frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (advance_o) begin
      pos_q <= item_i.last_byte ? '0 : pos_d;
    end
  end

  // Captured header fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q  <= '0;
      src_q   <= '0;
      outer_q <= '0;
      tag_q   <= '0;
      inner_q <= '0;
    end else if (advance_o) begin
      dest_q  <= dest_d;
      src_q   <= src_d;
      outer_q <= outer_d;
      tag_q   <= tag_d;
      inner_q <= inner_d;
    end
  end

  // A frame's final byte leaves the counter at zero.
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && item_i.last_byte |=> pos_q == '0)
    else $error("byte counter did not restart after a frame");

  // A middle byte below the limit steps the counter by one.
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && !item_i.last_byte && pos_q < PosW'(evhp_pkg::MaxFrameBytes)
    |=> pos_q == $past(pos_q) + PosW'(1))
    else $error("byte counter missed a step");

  // A stalled byte keeps the counter where it is.
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_o |=> $stable(pos_q))
    else $error("byte counter moved without a transfer");

  // Header size agrees with the tag and status fields.
  a_hdr_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.status == evhp_pkg::StatusShort && res_o.header_size == 5'd0)
                 || (res_o.vlan_present && res_o.header_size == evhp_pkg::HdrTagged)
                 || (!res_o.vlan_present && res_o.header_size == evhp_pkg::HdrUntagged))
    else $error("header size disagrees with tag and status");

endmodule

`default_nettype wire

/* hw/rtl/evhp_out_stage.sv */
`default_nettype none

module evhp_out_stage (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        res_valid_i,
  input  wire evhp_pkg::hdr_result_t res_i,
  output logic                       slot_free_o,
  evhp_hdr_if.source                 hdr_o
);

  logic                  valid_q;
  evhp_pkg::hdr_result_t res_q;

  // The register frees up when it is empty or its result transfers now.
  assign slot_free_o = !valid_q || hdr_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (slot_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign hdr_o.valid          = valid_q;
  assign hdr_o.status         = res_q.status;
  assign hdr_o.dest_addr      = res_q.dest_addr;
  assign hdr_o.src_addr       = res_q.src_addr;
  assign hdr_o.ether_type     = res_q.ether_type;
  assign hdr_o.vlan_present   = res_q.vlan_present;
  assign hdr_o.vlan_id        = res_q.vlan_id;
  assign hdr_o.priority_res   = res_q.priority_res;
  assign hdr_o.drop_eligible  = res_q.drop_eligible;
  assign hdr_o.header_size    = res_q.header_size;
  assign hdr_o.payload_length = res_q.payload_length;

endmodule

`default_nettype wire

/* hw/rtl/ethernet_vlan_header_parser_top.sv */
// Channel  Dir  Carries                                   Transfer
// rx_i     in   data_byte, last_byte                      valid && ready
// hdr_o    out  status, addresses, type, tag fields,      valid && ready
//               header_size, payload_length
//
// One byte is taken every cycle, unless a final byte waits on a full output register.
// A byte passes the input register, then the field capture and result logic;
// the final byte's result is then registered in the output register that drives hdr_o.
// Input ready stalls only while a final byte waits on a full output register.
// Reset clears the byte counter, the captured fields and both valid flags.
`default_nettype none

module ethernet_vlan_header_parser_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  evhp_byte_if.sink  rx_i,
  evhp_hdr_if.source hdr_o
);

  logic                  item_valid;
  evhp_pkg::byte_item_t  item;
  logic                  advance;
  logic                  res_valid;
  evhp_pkg::hdr_result_t res;
  logic                  slot_free;

  evhp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  evhp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .slot_free_i (slot_free),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  evhp_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .slot_free_o(slot_free),
    .hdr_o      (hdr_o)
  );

endmodule

`default_nettype wire

/* sim/ethernet_vlan_header_parser_top_tb.sv */
`timescale 1ns / 100ps

module ethernet_vlan_header_parser_top_tb;
  import evhp_pkg::*;

  localparam int unsigned CycleLimit     = 400_000;
  localparam int unsigned RandomBytes    = 1000;
  localparam int unsigned QuietBytes     = 820;
  localparam int unsigned MaxReports     = 10;

  // One frame to send: header words, length, and an optional hand-written result.
  typedef struct {
    int unsigned len;
    logic [47:0] dst;
    logic [47:0] src;
    logic [15:0] outer;
    logic [15:0] tag;
    logic [15:0] inner;
    bit          typed;
    hdr_result_t want;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  evhp_byte_if rx ();
  evhp_hdr_if  hdr ();

  ethernet_vlan_header_parser_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .hdr_o  (hdr)
  );

  // Header parser state as the block should hold it.
  logic [PosW-1:0] frame_pos  = '0;
  logic [47:0]     dest_sr    = '0;
  logic [47:0]     src_sr     = '0;
  logic [15:0]     outer_word = '0;
  logic [15:0]     tag_word   = '0;
  logic [15:0]     inner_word = '0;

  hdr_result_t pending_headers[$];
  frame_t      frames_in_flight[$];
  frame_t      directed_frames[$];

  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  bit          quiet_phase = 1'b0;

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advances the header capture by one byte; returns 1 with the result on the last byte.
  function automatic bit absorb_byte(input byte_item_t it, output hdr_result_t res);
    logic [PosW-1:0] pos;
    int unsigned     flen;
    int unsigned     hsize;
    logic [15:0]     word;
    pos = frame_pos;
    res = '0;
    if (pos < DestEnd) dest_sr = {dest_sr[39:0], it.data_byte};
    else if (pos < SrcEnd) src_sr = {src_sr[39:0], it.data_byte};
    else if (pos < TypeEnd) outer_word = {outer_word[7:0], it.data_byte};
    else if (pos < TagEnd) tag_word = {tag_word[7:0], it.data_byte};
    else if (pos < InnerEnd) inner_word = {inner_word[7:0], it.data_byte};
    // The counter sticks at its maximum, so very long frames count as that long.
    if (pos < MaxFrameBytes) frame_pos = pos + 1'b1;
    if (!it.last_byte) return 1'b0;

    flen = 32'(frame_pos);
    if (flen < TypeEnd || (outer_word == VlanTpid && flen < InnerEnd)) begin
      res.status = StatusShort;
    end else begin
      res.status    = StatusOk;
      res.dest_addr = dest_sr;
      res.src_addr  = src_sr;
      if (outer_word == VlanTpid) begin
        res.vlan_present  = 1'b1;
        res.vlan_id       = tag_word[11:0];
        res.priority_res  = tag_word[15:13];
        res.drop_eligible = tag_word[12];
        res.header_size   = HdrTagged;
        word              = inner_word;
      end else begin
        res.header_size = HdrUntagged;
        word            = outer_word;
      end
      // A word of 1500 or less is a length, not a type.
      res.ether_type = (word > LengthLimit) ? word : 16'h0000;
      hsize = 32'(res.header_size);
      res.payload_length = (flen - hsize > PayloadMax) ? PayW'(PayloadMax)
                                                       : PayW'(flen - hsize);
    end

    frame_pos  = '0;
    dest_sr    = '0;
    src_sr     = '0;
    outer_word = '0;
    tag_word   = '0;
    inner_word = '0;
    return 1'b1;
  endfunction

  function automatic hdr_result_t mk_result(input logic status, input logic [47:0] dst,
                                            input logic [47:0] src, input logic [15:0] etype,
                                            input logic vlan, input logic [11:0] vid,
                                            input logic [2:0] pcp, input logic dei,
                                            input logic [4:0] hsize,
                                            input logic [PayW-1:0] pay);
    hdr_result_t res;
    res.status         = status;
    res.dest_addr      = dst;
    res.src_addr       = src;
    res.ether_type     = etype;
    res.vlan_present   = vlan;
    res.vlan_id        = vid;
    res.priority_res   = pcp;
    res.drop_eligible  = dei;
    res.header_size    = hsize;
    res.payload_length = pay;
    return res;
  endfunction

  function automatic frame_t row(input int unsigned len, input logic [47:0] dst,
                                 input logic [47:0] src, input logic [15:0] outer,
                                 input logic [15:0] tag, input logic [15:0] inner,
                                 input bit typed, input hdr_result_t want);
    frame_t fr;
    fr.len   = len;
    fr.dst   = dst;
    fr.src   = src;
    fr.outer = outer;
    fr.tag   = tag;
    fr.inner = inner;
    fr.typed = typed;
    fr.want  = want;
    return fr;
  endfunction

  // Directed frames: extremes, short frames and tag boundaries.
  function automatic void load_directed();
    hdr_result_t short_res;
    logic [47:0] ones;
    ones      = '1;
    short_res = mk_result(StatusShort, '0, '0, '0, 1'b0, '0, '0, 1'b0, HdrNone, '0);
    directed_frames.push_back(row(1, ones, ones, '1, '1, '1, 1'b1, short_res));
    directed_frames.push_back(row(13, ones, ones, '1, '1, '1, 1'b1, short_res));
    directed_frames.push_back(row(14, '0, '0, '0, '0, '0, 1'b1,
      mk_result(StatusOk, '0, '0, '0, 1'b0, '0, '0, 1'b0, HdrUntagged, '0)));
    directed_frames.push_back(row(14, ones, ones, '1, '1, '1, 1'b1,
      mk_result(StatusOk, ones, ones, 16'hFFFF, 1'b0, '0, '0, 1'b0, HdrUntagged, '0)));
    directed_frames.push_back(row(60, 48'h0123456789AB, 48'hFEDCBA987654, LengthLimit,
      '0, '0, 1'b1, mk_result(StatusOk, 48'h0123456789AB, 48'hFEDCBA987654, '0, 1'b0,
      '0, '0, 1'b0, HdrUntagged, PayW'(46))));
    directed_frames.push_back(row(61, 48'h00005E000101, 48'h02AABBCCDDEE,
      LengthLimit + 16'd1, '0, '0, 1'b0, '0));
    directed_frames.push_back(row(14, 48'h111111111111, 48'h222222222222, VlanTpid,
      '1, '1, 1'b1, short_res));
    directed_frames.push_back(row(17, 48'h333333333333, 48'h444444444444, VlanTpid,
      '1, '1, 1'b1, short_res));
    directed_frames.push_back(row(18, ones, ones, VlanTpid, '1, '1, 1'b1,
      mk_result(StatusOk, ones, ones, 16'hFFFF, 1'b1, 12'hFFF, 3'd7, 1'b1, HdrTagged, '0)));
    directed_frames.push_back(row(18, '0, '0, VlanTpid, '0, '0, 1'b1,
      mk_result(StatusOk, '0, '0, '0, 1'b1, '0, '0, 1'b0, HdrTagged, '0)));
    directed_frames.push_back(row(40, 48'hA5A5A5A5A5A5, 48'h5A5A5A5A5A5A, VlanTpid,
      16'hA123, LengthLimit, 1'b0, '0));
    directed_frames.push_back(row(41, 48'h0F0F0F0F0F0F, 48'hF0F0F0F0F0F0, VlanTpid,
      16'h5FFF, 16'h0800, 1'b0, '0));
    directed_frames.push_back(row(20, 48'h00000000FFFF, 48'hFFFF00000000, VlanTpid,
      16'h2064, LengthLimit + 16'd1, 1'b0, '0));
    directed_frames.push_back(row(30, 48'h123456789ABC, 48'hCBA987654321, 16'h8101,
      16'h1234, 16'h5678, 1'b0, '0));
    directed_frames.push_back(row(64, 48'h800000000001, 48'h7FFFFFFFFFFE, 16'h88A8,
      16'h8100, 16'h0800, 1'b0, '0));
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, LengthLimit));
      2:       return LengthLimit;
      3:       return LengthLimit + 16'd1;
      4:       return 16'h0800;
      default: return 16'h86DD;
    endcase
  endfunction

  // Mostly well-formed frames with random content, plus some that end too early.
  function automatic frame_t random_frame();
    frame_t      fr;
    int unsigned pick;
    fr.dst   = 48'({$urandom, $urandom});
    fr.src   = 48'({$urandom, $urandom});
    fr.tag   = 16'($urandom);
    fr.inner = pick_word();
    fr.typed = 1'b0;
    fr.want  = '0;
    pick     = $urandom_range(0, 19);
    if (pick < 2) begin
      fr.outer = pick_word();
      fr.len   = $urandom_range(1, TypeEnd - 1);
    end else if (pick < 3) begin
      fr.outer = VlanTpid;
      fr.len   = $urandom_range(TypeEnd, InnerEnd - 1);
    end else if (pick < 11) begin
      fr.outer = pick_word();
      fr.len   = $urandom_range(TypeEnd, 40);
    end else begin
      fr.outer = VlanTpid;
      fr.len   = $urandom_range(InnerEnd, 44);
    end
    return fr;
  endfunction

  function automatic logic [7:0] frame_byte(input frame_t fr, input int unsigned k);
    if (k < DestEnd) return fr.dst[47 - 8 * k -: 8];
    if (k < SrcEnd) return fr.src[47 - 8 * (k - DestEnd) -: 8];
    if (k < TypeEnd) return fr.outer[15 - 8 * (k - SrcEnd) -: 8];
    if (k < TagEnd) return fr.tag[15 - 8 * (k - TypeEnd) -: 8];
    if (k < InnerEnd) return fr.inner[15 - 8 * (k - TagEnd) -: 8];
    return 8'($urandom);
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MaxReports) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= MaxReports) begin
        $display("mismatch: %s expected %h, got %h", name, want, got);
      end
    end
  endtask

  // Holds valid low, with noise on the payload lines.
  task automatic idle_burst(input int unsigned cycles);
    rx.valid     <= 1'b0;
    rx.data_byte <= 8'($urandom);
    rx.last_byte <= 1'($urandom);
    repeat (cycles) @(negedge clk_i);
  endtask

  // Sends one frame byte by byte; each byte waits for its transfer.
  task automatic send_frame(input frame_t fr);
    bit gappy;
    gappy = !quiet_phase && $urandom_range(0, 3) != 0;
    frames_in_flight.push_back(fr);
    for (int unsigned k = 0; k < fr.len; k++) begin
      if (gappy && $urandom_range(0, 4) == 0) idle_burst($urandom_range(1, 4));
      rx.valid     <= 1'b1;
      rx.data_byte <= frame_byte(fr, k);
      rx.last_byte <= (k == fr.len - 1);
      @(posedge clk_i);
      while (!rx.ready) @(posedge clk_i);
      @(negedge clk_i);
    end
  endtask

  // Result sink: random stall bursts, calm stretches, and no stalls at the end.
  initial begin : hdr_sink
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left  = 0;
    hdr.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet_phase || calm_left > 0) begin
        hdr.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
      end else if (stall_left > 0) begin
        hdr.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        hdr.ready  <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        hdr.ready <= 1'b1;
        if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 60);
      end
    end
  end

  // Checks each result transfer, then feeds each byte transfer to the predictor.
  always @(posedge clk_i) begin : watch
    hdr_result_t got;
    hdr_result_t want;
    frame_t      fr;
    if (rst_ni) begin
      if (hdr.valid && hdr.ready) begin
        if (pending_headers.size() == 0) begin
          note_fault("result with no frame waiting");
        end else begin
          want = pending_headers.pop_front();
          check_field("status", 48'(want.status), 48'(hdr.status));
          check_field("dest_addr", want.dest_addr, hdr.dest_addr);
          check_field("src_addr", want.src_addr, hdr.src_addr);
          check_field("ether_type", 48'(want.ether_type), 48'(hdr.ether_type));
          check_field("vlan_present", 48'(want.vlan_present), 48'(hdr.vlan_present));
          check_field("vlan_id", 48'(want.vlan_id), 48'(hdr.vlan_id));
          check_field("priority_res", 48'(want.priority_res), 48'(hdr.priority_res));
          check_field("drop_eligible", 48'(want.drop_eligible),
                      48'(hdr.drop_eligible));
          check_field("header_size", 48'(want.header_size), 48'(hdr.header_size));
          check_field("payload_length", 48'(want.payload_length),
                      48'(hdr.payload_length));
        end
      end
      if (rx.valid && rx.ready) begin
        if (absorb_byte({rx.data_byte, rx.last_byte}, got)) begin
          // Hand-written results take the place of the predicted one.
          if (frames_in_flight.size() != 0) begin
            fr = frames_in_flight.pop_front();
            pending_headers.push_back(fr.typed ? fr.want : got);
          end else begin
            pending_headers.push_back(got);
          end
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    frame_t      fr;
    int unsigned sent_bytes;
    rst_ni       = 1'b0;
    rx.valid     = 1'b0;
    rx.data_byte = 8'h00;
    rx.last_byte = 1'b0;
    load_directed();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_frames[i]) send_frame(directed_frames[i]);

    // Hold the sender until every directed result has been seen.
    rx.valid <= 1'b0;
    do @(negedge clk_i); while (pending_headers.size() != 0);

    sent_bytes = 0;
    while (sent_bytes < RandomBytes) begin
      quiet_phase = sent_bytes >= QuietBytes;
      fr = random_frame();
      send_frame(fr);
      sent_bytes += fr.len;
    end
    rx.valid <= 1'b0;

    // Drain, then keep watching for any stray result before the verdict.
    while (pending_headers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fault_count == 0 && pending_headers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
